// ===== design/tkpq_pkg.sv =====
package tkpq_pkg;

   // Request codes.
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_POP    = 1'b1;

   // Result status codes.
   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic        mode;
      logic [7:0]  severity_in;
      logic [31:0] arrival_in;
      logic [31:0] tag_in;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  severity_out;
      logic [31:0] arrival_out;
      logic [31:0] tag_out;
      logic [4:0]  occupancy;
   } rsp_type;

   // One stored queue entry, as kept in the entry memory.
   typedef struct packed {
      logic [7:0]  severity;
      logic [31:0] arrival;
      logic [31:0] tag;
   } entry_type;

   // Controller to datapath.
   typedef struct packed {
      logic       accept;
      logic       insert;
      logic       scan_init;
      logic       scan;
      logic       shift_init;
      logic       shift;
      logic       dec;
      logic       emit;
      logic       emit_entry;
      logic [1:0] code;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic full;
      logic empty;
      logic scan_last;
      logic shift_done;
   } sts_type;

endpackage

// ===== design/tkpq_ram.sv =====
module tkpq_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/tkpq_ctrl.sv =====
module tkpq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              mode,
   input  tkpq_pkg::sts_type sts,
   output tkpq_pkg::cmd_type cmd,
   output logic              busy
);

   typedef enum logic [4:0] {
      S_IDLE       = 5'b00001,
      S_INSERT     = 5'b00010,
      S_SCAN       = 5'b00100,
      S_SHIFT_INIT = 5'b01000,
      S_SHIFT      = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.code = tkpq_pkg::STATUS_DONE;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               if (mode == tkpq_pkg::MODE_INSERT) begin
                  if (sts.full) begin
                     cmd.emit = 1'b1;
                     cmd.code = tkpq_pkg::STATUS_FULL;
                  end else begin
                     state_in = S_INSERT;
                  end
               end else if (sts.empty) begin
                  cmd.emit = 1'b1;
                  cmd.code = tkpq_pkg::STATUS_EMPTY;
               end else begin
                  cmd.scan_init = 1'b1;
                  state_in      = S_SCAN;
               end
            end
         end
         S_INSERT: begin
            cmd.insert = 1'b1;
            cmd.emit   = 1'b1;
            state_in   = S_IDLE;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_last) begin
               state_in = S_SHIFT_INIT;
            end
         end
         S_SHIFT_INIT: begin
            cmd.shift_init = 1'b1;
            state_in       = S_SHIFT;
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (sts.shift_done) begin
               cmd.dec        = 1'b1;
               cmd.emit       = 1'b1;
               cmd.emit_entry = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ===== design/tkpq_dp.sv =====
module tkpq_dp #(
   parameter int CAPACITY = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  tkpq_pkg::cmd_type cmd,
   input  tkpq_pkg::req_type req_data,
   output tkpq_pkg::sts_type sts,
   output tkpq_pkg::rsp_type rsp_data,
   output logic              rsp_strobe
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    ptr_ff, ptr_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]    pend_idx_ff, pend_idx_in;
   logic [IDX_W-1:0]    best_idx_ff, best_idx_in;
   tkpq_pkg::entry_type best_ff, best_in;
   tkpq_pkg::req_type   req_ff, req_in;
   tkpq_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_strobe_ff, rsp_strobe_in;

   logic                ram_we;
   logic [IDX_W-1:0]    ram_waddr;
   logic [IDX_W-1:0]    ram_raddr;
   tkpq_pkg::entry_type ram_wdata;
   tkpq_pkg::entry_type ram_rdata;
   logic                beats;

   tkpq_ram #(
      .WIDTH($bits(tkpq_pkg::entry_type)),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // Higher severity wins; on equal severity the smaller arrival key wins.
   assign beats = (ram_rdata.severity > best_ff.severity) ||
                  ((ram_rdata.severity == best_ff.severity) &&
                   (ram_rdata.arrival < best_ff.arrival));

   always_comb begin
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      best_idx_in   = best_idx_ff;
      best_in       = best_ff;
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = count_ff[IDX_W-1:0];
      ram_wdata     = ram_rdata;
      ram_raddr     = (ptr_ff < count_ff) ? ptr_ff[IDX_W-1:0] : '0;

      if (cmd.accept) begin
         req_in = req_data;
      end

      if (cmd.scan_init) begin
         ptr_in        = '0;
         pend_valid_in = 1'b0;
      end

      if (cmd.shift_init) begin
         ptr_in        = CNT_W'(best_idx_ff) + CNT_W'(1);
         pend_valid_in = 1'b0;
      end

      // One read a cycle; the entry returns in the next cycle, tagged by its slot.
      if (cmd.scan || cmd.shift) begin
         pend_idx_in = ptr_ff[IDX_W-1:0];
         if (ptr_ff < count_ff) begin
            ptr_in        = ptr_ff + CNT_W'(1);
            pend_valid_in = 1'b1;
         end else begin
            pend_valid_in = 1'b0;
         end
      end

      if (cmd.scan && pend_valid_ff) begin
         if ((pend_idx_ff == '0) || beats) begin
            best_in     = ram_rdata;
            best_idx_in = pend_idx_ff;
         end
      end

      if (cmd.insert) begin
         ram_we             = 1'b1;
         ram_waddr          = count_ff[IDX_W-1:0];
         ram_wdata.severity = req_ff.severity_in;
         ram_wdata.arrival  = req_ff.arrival_in;
         ram_wdata.tag      = req_ff.tag_in;
         count_in           = count_ff + CNT_W'(1);
      end

      // Each entry above the removed one moves down by one slot.
      if (cmd.shift && pend_valid_ff) begin
         ram_we    = 1'b1;
         ram_waddr = pend_idx_ff - IDX_W'(1);
         ram_wdata = ram_rdata;
      end

      if (cmd.dec) begin
         count_in = count_ff - CNT_W'(1);
      end

      if (cmd.emit) begin
         rsp_strobe_in    = 1'b1;
         rsp_in.status    = cmd.code;
         rsp_in.occupancy = 5'(count_in);
         if (cmd.emit_entry) begin
            rsp_in.severity_out = best_ff.severity;
            rsp_in.arrival_out  = best_ff.arrival;
            rsp_in.tag_out      = best_ff.tag;
         end else begin
            rsp_in.severity_out = '0;
            rsp_in.arrival_out  = '0;
            rsp_in.tag_out      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      pend_idx_ff <= pend_idx_in;
      best_idx_ff <= best_idx_in;
      best_ff     <= best_in;
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
   end

   assign sts.full       = (count_ff == CNT_W'(CAPACITY));
   assign sts.empty      = (count_ff == '0);
   assign sts.scan_last  = pend_valid_ff &&
                           (CNT_W'(pend_idx_ff) == (count_ff - CNT_W'(1)));
   assign sts.shift_done = (ptr_ff >= count_ff);

   assign rsp_data   = rsp_ff;
   assign rsp_strobe = rsp_strobe_ff;

endmodule

// ===== design/two_key_priority_queue_core.sv =====
// Two-key priority queue holding up to CAPACITY entries of severity, arrival
// key and tag. A request beat is taken at a rising clock edge where start is
// high and busy is low; req_data.mode selects an insert or a pop.
// Every request gives exactly one result beat: rsp_strobe is high for one
// cycle with rsp_data valid in that same cycle. The receiver cannot stall,
// so results are never held back.
// An insert passes through the insert state, which keeps busy high, and its
// result beat is registered from there. A request refused because the queue
// is full or empty has its result beat registered straight from the idle
// state and never raises busy. A pop walks the stored entries through the
// single read port of the entry memory, one per cycle, then moves the later
// entries down one slot, again one per cycle. Busy stays high through the
// scan, shift-init and shift states and drops as the result beat appears.
// The next request may be accepted while the previous result beat is still
// on the result ports.
// Reset clears the entry count and the controller; the entry memory is not
// cleared since only slots below the count are ever used.
module two_key_priority_queue_core #(
   parameter int CAPACITY = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tkpq_pkg::req_type req_data,
   output logic              rsp_strobe,
   output tkpq_pkg::rsp_type rsp_data
);

   tkpq_pkg::cmd_type cmd;
   tkpq_pkg::sts_type sts;

   // Sequencing of insert, scan and shift steps.
   tkpq_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .mode (req_data.mode),
      .sts  (sts),
      .cmd  (cmd),
      .busy (busy)
   );

   // Entry memory, count, scan pointer and the best-entry registers.
   tkpq_dp #(
      .CAPACITY(CAPACITY)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .sts       (sts),
      .rsp_data  (rsp_data),
      .rsp_strobe(rsp_strobe)
   );

endmodule
